[src/omws_pkg.sv]
`default_nettype none
package omws_pkg;
	localparam int WHEELS_DEF = 4;
	localparam int AXLE_REGS  = 8;
	localparam int AXLE_W     = 15;
	localparam int IDX_W      = 3;
	localparam int NUM_W      = 37;
	localparam int DEN_W      = 22;
	localparam int FRAC_SH    = 6;

	localparam logic signed [15:0] SPIN_CLIP = 16'sd9600;
	localparam logic signed [20:0] SLEW_STEP = 21'sd640;
	localparam logic [11:0]        HALF_TURN = 12'd1800;
	localparam logic [11:0]        QUARTER   = 12'd900;
	localparam logic [11:0]        FULL_TURN = 12'd3600;
	localparam logic [DEN_W-1:0]   DEN_BASE  = 22'd4050000;
	localparam logic [46:0]        DOT_HALF  = 47'd1 << 27;
endpackage
`default_nettype wire

[src/omws_div.sv]
`default_nettype none
module omws_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [omws_pkg::NUM_W-1:0]   num,
	input  wire [omws_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [omws_pkg::NUM_W-1:0]  quot
);
	localparam int NW  = omws_pkg::NUM_W;
	localparam int DW  = omws_pkg::DEN_W;
	localparam int CW  = $clog2(NW + 1);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule
`default_nettype wire

[src/omni_wheel_mixer_slew.sv]
`default_nettype none
// Four-wheel omni drive mixer. Each item carries a field-frame velocity, spin rate,
// heading and wheel speed limit; the block rotates each wheel axle by the heading,
// forms the wheel target speeds, scales them under the limit and slews each stored
// wheel level by at most 10 units before emitting four signed bytes. One shared
// 32x17 multiplier and one radix-2 divider do all the arithmetic under a
// sequencer: sine and cosine take two divisions, each wheel takes six
// multiplies, and scaling, when the limit is exceeded, adds one multiply and
// one division per wheel. The block holds s_tready low while it works. Axle
// registers may be written only while idle.
module omni_wheel_mixer_slew #(
	parameter int WHEELS = omws_pkg::WHEELS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// vel_x[15:0], vel_y[31:16], spin_rate[47:32], heading[59:48], speed_limit[66:60]
	input  wire  [71:0]                  s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// motor0[7:0], motor1[15:8], motor2[23:16], motor3[31:24]
	output logic [31:0]                  m_tdata,
	input  wire                          cfg_we,
	input  wire  [omws_pkg::IDX_W-1:0]   cfg_index,
	input  wire  [omws_pkg::AXLE_W-1:0]  cfg_data
);
	localparam int WI_W = $clog2(WHEELS);
	localparam logic [WI_W-1:0] WI_LAST = WI_W'(WHEELS - 1);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_TRIG_MUL  = 4'd1;
	localparam logic [3:0] ST_TRIG_DIV  = 4'd2;
	localparam logic [3:0] ST_TRIG_WAIT = 4'd3;
	localparam logic [3:0] ST_MUL       = 4'd4;
	localparam logic [3:0] ST_ACC       = 4'd5;
	localparam logic [3:0] ST_SC_MUL    = 4'd6;
	localparam logic [3:0] ST_SC_DIV    = 4'd7;
	localparam logic [3:0] ST_SC_WAIT   = 4'd8;
	localparam logic [3:0] ST_DONE      = 4'd9;

	localparam logic [2:0] K_AXC = 3'd0;
	localparam logic [2:0] K_AYS = 3'd1;
	localparam logic [2:0] K_AXS = 3'd2;
	localparam logic [2:0] K_AYC = 3'd3;
	localparam logic [2:0] K_RYV = 3'd4;
	localparam logic [2:0] K_RXV = 3'd5;

	logic [3:0]                state_q;
	logic signed [14:0]        axle_q [omws_pkg::AXLE_REGS];
	logic signed [15:0]        vx_q, vy_q, w_q;
	logic [12:0]               lim_q;
	logic [11:0]               ang_q;
	logic                      pass_q;
	logic                      sneg_q;
	logic signed [15:0]        sin_q, cos_q;
	logic [2:0]                k_q;
	logic [WI_W-1:0]           wi_q;
	logic signed [48:0]        prod_q, acc_q;
	logic signed [30:0]        rx_q, ry_q;
	logic signed [19:0]        tgt_q [WHEELS];
	logic [18:0]               maxv_q;
	logic signed [15:0]        lvl_q [WHEELS];
	logic                      m_tvalid_q;
	logic [31:0]               m_tdata_q;

	logic signed [31:0]        mul_a;
	logic signed [16:0]        mul_b;
	logic signed [48:0]        mul_p;
	logic [10:0]               t2;
	logic                      tneg;
	logic signed [14:0]        ax, ay;
	logic [omws_pkg::IDX_W-1:0] ax_idx, ay_idx;
	logic signed [48:0]        dot;
	logic [46:0]               dot_mag;
	logic [18:0]               dot_q;
	logic signed [19:0]        v_c;
	logic [18:0]               va_c;
	logic [18:0]               maxv_c;
	logic [18:0]               tmag;
	logic                      div_start;
	logic [omws_pkg::NUM_W-1:0] div_num;
	logic [omws_pkg::DEN_W-1:0] div_den;
	logic                      div_done;
	logic [omws_pkg::NUM_W-1:0] div_quot;
	logic [19:0]               pdiv;
	logic signed [15:0]        lvl_n [WHEELS];
	logic [31:0]               out_c;
	logic                      out_free;
	logic signed [15:0]        in_w;
	logic signed [11:0]        in_hd;
	logic [11:0]               in_ang;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign in_w   = $signed(s_tdata[47:32]);
	assign in_hd  = $signed(s_tdata[59:48]);
	assign in_ang = in_hd[11] ? s_tdata[59:48] + omws_pkg::FULL_TURN : s_tdata[59:48];

	assign tneg = ang_q >= omws_pkg::HALF_TURN;
	assign t2   = tneg ? 11'(ang_q - omws_pkg::HALF_TURN) : ang_q[10:0];

	assign ax_idx = omws_pkg::IDX_W'({wi_q, 1'b0});
	assign ay_idx = omws_pkg::IDX_W'({wi_q, 1'b1});
	assign ax     = axle_q[ax_idx];
	assign ay     = axle_q[ay_idx];
	assign tmag   = tgt_q[wi_q][19] ? 19'(-tgt_q[wi_q]) : tgt_q[wi_q][18:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TRIG_MUL: begin
				mul_a = $signed({21'd0, t2});
				mul_b = $signed({6'd0, 11'(omws_pkg::HALF_TURN[10:0] - t2)});
			end
			ST_MUL: begin
				case (k_q)
					K_AXC: begin mul_a = 32'(ax); mul_b = 17'(cos_q); end
					K_AYS: begin mul_a = 32'(ay); mul_b = 17'(sin_q); end
					K_AXS: begin mul_a = 32'(ax); mul_b = 17'(sin_q); end
					K_AYC: begin mul_a = 32'(ay); mul_b = 17'(cos_q); end
					K_RYV: begin mul_a = 32'(ry_q); mul_b = 17'(vx_q); end
					K_RXV: begin mul_a = 32'(rx_q); mul_b = 17'(vy_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_SC_MUL: begin
				mul_a = $signed({13'd0, tmag});
				mul_b = $signed({4'd0, lim_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign dot     = acc_q - prod_q;
	assign dot_mag = dot[48] ? 47'(-dot) : dot[46:0];
	assign dot_q   = 19'((dot_mag + omws_pkg::DOT_HALF) >> 28);
	assign v_c     = (dot[48] ? -$signed({1'b0, dot_q}) : $signed({1'b0, dot_q})) + 20'(w_q);
	assign va_c    = v_c[19] ? 19'(-v_c) : v_c[18:0];
	assign maxv_c  = (va_c > maxv_q) ? va_c : maxv_q;

	assign pdiv = prod_q[19:0];

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_TRIG_DIV: begin
				div_start = 1'b1;
				div_den   = omws_pkg::DEN_BASE - 22'(pdiv);
				div_num   = {1'b0, pdiv, 16'd0} + 37'(div_den >> 1);
			end
			ST_SC_DIV: begin
				div_start = 1'b1;
				div_den   = 22'(maxv_q);
				div_num   = prod_q[36:0] + 37'(maxv_q >> 1);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	omws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		logic signed [20:0] ch;
		logic [15:0]        mag;
		logic [7:0]         mb;
		out_c = '0;
		for (int i = 0; i < WHEELS; i++) begin
			ch = 21'(tgt_q[i]) - 21'(lvl_q[i]);
			if (ch > omws_pkg::SLEW_STEP) begin
				ch = omws_pkg::SLEW_STEP;
			end else if (ch < -omws_pkg::SLEW_STEP) begin
				ch = -omws_pkg::SLEW_STEP;
			end
			lvl_n[i] = lvl_q[i] + ch[15:0];
			mag      = lvl_n[i][15] ? 16'(-lvl_n[i]) : lvl_n[i];
			mb       = 8'(mag >> omws_pkg::FRAC_SH);
			out_c[8*i +: 8] = lvl_n[i][15] ? 8'(-mb) : mb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < omws_pkg::AXLE_REGS; i++) begin
				axle_q[i] <= '0;
			end
		end else if (cfg_we) begin
			axle_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			pass_q     <= 1'b0;
			k_q        <= K_AXC;
			wi_q       <= '0;
			for (int i = 0; i < WHEELS; i++) begin
				lvl_q[i] <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pass_q  <= 1'b0;
						state_q <= ST_TRIG_MUL;
					end
				end
				ST_TRIG_MUL: state_q <= ST_TRIG_DIV;
				ST_TRIG_DIV: state_q <= ST_TRIG_WAIT;
				ST_TRIG_WAIT: begin
					if (div_done) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= ST_TRIG_MUL;
						end else begin
							k_q     <= K_AXC;
							wi_q    <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					state_q <= ST_MUL;
					if (k_q == K_RXV) begin
						k_q <= K_AXC;
						if (wi_q == WI_LAST) begin
							wi_q    <= '0;
							state_q <= (maxv_c > 19'(lim_q)) ? ST_SC_MUL : ST_DONE;
						end else begin
							wi_q <= wi_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SC_MUL: state_q <= ST_SC_DIV;
				ST_SC_DIV: state_q <= ST_SC_WAIT;
				ST_SC_WAIT: begin
					if (div_done) begin
						if (wi_q == WI_LAST) begin
							state_q <= ST_DONE;
						end else begin
							wi_q    <= wi_q + 1'b1;
							state_q <= ST_SC_MUL;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						for (int i = 0; i < WHEELS; i++) begin
							lvl_q[i] <= lvl_n[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vx_q  <= $signed(s_tdata[15:0]);
				vy_q  <= $signed(s_tdata[31:16]);
				lim_q <= {s_tdata[66:60], 6'd0};
				ang_q <= in_ang;
				if (in_w > omws_pkg::SPIN_CLIP) begin
					w_q <= omws_pkg::SPIN_CLIP;
				end else if (in_w < -omws_pkg::SPIN_CLIP) begin
					w_q <= -omws_pkg::SPIN_CLIP;
				end else begin
					w_q <= in_w;
				end
			end
			ST_TRIG_MUL: begin
				prod_q <= mul_p;
				sneg_q <= tneg;
			end
			ST_TRIG_WAIT: begin
				if (div_done) begin
					if (!pass_q) begin
						sin_q <= sneg_q ? -$signed({1'b0, div_quot[14:0]})
						                : $signed({1'b0, div_quot[14:0]});
						ang_q <= (ang_q >= omws_pkg::FULL_TURN - omws_pkg::QUARTER)
						         ? ang_q - (omws_pkg::FULL_TURN - omws_pkg::QUARTER)
						         : ang_q + omws_pkg::QUARTER;
					end else begin
						cos_q <= sneg_q ? -$signed({1'b0, div_quot[14:0]})
						                : $signed({1'b0, div_quot[14:0]});
					end
					maxv_q <= '0;
				end
			end
			ST_MUL: prod_q <= mul_p;
			ST_ACC: begin
				case (k_q)
					K_AXC: acc_q <= prod_q;
					K_AYS: rx_q  <= 31'(acc_q - prod_q);
					K_AXS: acc_q <= prod_q;
					K_AYC: ry_q  <= 31'(acc_q + prod_q);
					K_RYV: acc_q <= prod_q;
					K_RXV: begin
						tgt_q[wi_q] <= v_c;
						maxv_q      <= maxv_c;
					end
					default: acc_q <= acc_q;
				endcase
			end
			ST_SC_MUL: prod_q <= mul_p;
			ST_SC_WAIT: begin
				if (div_done) begin
					tgt_q[wi_q] <= tgt_q[wi_q][19] ? -$signed({1'b0, div_quot[18:0]})
					                               : $signed({1'b0, div_quot[18:0]});
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= out_c;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

`ifndef SYNTH
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_TRIG_MUL)
		else $error("accepted item did not start the sequencer");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_TRIG_WAIT || state_q == ST_SC_WAIT))
		else $error("divider finished outside a wait state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final step");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q[0] <= 16'sd8128 && lvl_q[0] >= -16'sd8128)
		else $error("wheel level beyond the largest limit");
`endif
endmodule
`default_nettype wire
